@@ hw/rtl/banked_cartridge_mapper_rtc_assert.svh @@
// Assertion macros shared by the cartridge mapper RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in the using module.
`ifndef BANKED_CARTRIDGE_MAPPER_RTC_ASSERT_SVH
`define BANKED_CARTRIDGE_MAPPER_RTC_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BCM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define BCM_ASSERT_IMPL(label, cond, cons, msg) \
    `BCM_ASSERT(label, (cond) |-> (cons), msg)

// Check that a condition implies a consequence in the next cycle.
`define BCM_ASSERT_NEXT(label, cond, cons, msg) \
    `BCM_ASSERT(label, (cond) |=> (cons), msg)

`endif

@@ hw/rtl/bcm_pkg.sv @@
// Shared types and constants of the banked cartridge mapper with real-time clock.
// No dependencies; used by bcm_rtc and banked_cartridge_mapper_rtc.
package bcm_pkg;

    // Request kinds carried in s_tuser
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Clock register indexes (select minus 8)
    localparam logic [2:0] CLK_SEC  = 3'd0;
    localparam logic [2:0] CLK_MIN  = 3'd1;
    localparam logic [2:0] CLK_HOUR = 3'd2;
    localparam logic [2:0] CLK_DAYL = 3'd3;
    localparam logic [2:0] CLK_DAYH = 3'd4;

    // Select values that map the clock registers
    localparam logic [3:0] SEL_CLK_FIRST = 4'h8;
    localparam logic [3:0] SEL_CLK_LAST  = 4'hC;

    // Mapper constants
    localparam logic [3:0] ENABLE_KEY   = 4'hA;
    localparam logic [7:0] LATCH_ARM    = 8'h00;
    localparam logic [7:0] LATCH_FIRE   = 8'h01;
    localparam logic [7:0] OPEN_BUS     = 8'hFF;
    localparam logic [23:0] TPS_RESET   = 24'd32768;

    // Parameter defaults
    localparam int RAM_BANK_BYTES_DEF = 8192;
    localparam int RAM_BANKS_DEF      = 4;
    localparam int ROM_BANK_BITS_DEF  = 7;

    // Control from the mapper to the clock
    typedef struct packed {
        logic       tick;
        logic       latch;
        logic       wr_en;
        logic [2:0] wr_reg;
        logic [7:0] wr_data;
    } rtc_ctl_t;

endpackage

@@ hw/rtl/bcm_rtc.sv @@
// Real-time clock of the cartridge mapper: live counters, sub-second divider, latched copy.
// Depends on bcm_pkg for the control struct and clock register codes.
module bcm_rtc (
    input  logic             aclk,
    input  logic             aresetn,
    input  bcm_pkg::rtc_ctl_t ctl,
    input  logic [23:0]      ticks_per_second,
    input  logic [2:0]       rd_sel,
    output logic [7:0]       rd_byte
);

    logic [23:0] sub_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hour_reg;
    logic [8:0]  day_reg;
    logic        halt_reg;
    logic        carry_reg;
    logic [7:0]  lat_reg [5];

    logic [23:0] limit;
    logic [24:0] sub_inc;
    logic        second_pass;

    // Divide ticks down to seconds
    always_comb begin
        limit       = (ticks_per_second == 24'd0) ? 24'd1 : ticks_per_second;
        sub_inc     = {1'b0, sub_reg} + 25'd1;
        second_pass = (sub_inc >= {1'b0, limit});
    end

    // Read the latched copy
    always_comb begin
        rd_byte = 8'h00;
        if (rd_sel <= bcm_pkg::CLK_DAYH) begin
            rd_byte = lat_reg[rd_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= '0;
            sec_reg   <= '0;
            min_reg   <= '0;
            hour_reg  <= '0;
            day_reg   <= '0;
            halt_reg  <= 1'b0;
            carry_reg <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                lat_reg[i] <= '0;
            end
        end else begin
            // Advance the live clock while running
            if (ctl.tick && !halt_reg) begin
                if (second_pass) begin
                    sub_reg <= '0;
                    if (sec_reg != 6'd59) begin
                        sec_reg <= sec_reg + 6'd1;
                    end else begin
                        sec_reg <= '0;
                        if (min_reg != 6'd59) begin
                            min_reg <= min_reg + 6'd1;
                        end else begin
                            min_reg <= '0;
                            if (hour_reg != 5'd23) begin
                                hour_reg <= hour_reg + 5'd1;
                            end else begin
                                hour_reg <= '0;
                                if (day_reg == 9'd511) begin
                                    day_reg   <= '0;
                                    carry_reg <= 1'b1;
                                end else begin
                                    day_reg <= day_reg + 9'd1;
                                end
                            end
                        end
                    end
                end else begin
                    sub_reg <= sub_inc[23:0];
                end
            end

            // Copy the live clock into the latched registers
            if (ctl.latch) begin
                lat_reg[0] <= {2'b00, sec_reg};
                lat_reg[1] <= {2'b00, min_reg};
                lat_reg[2] <= {3'b000, hour_reg};
                lat_reg[3] <= day_reg[7:0];
                lat_reg[4] <= {carry_reg, halt_reg, 5'b00000, day_reg[8]};
            end

            // Apply a clock register write; day-high always, others only while halted
            if (ctl.wr_en) begin
                if (ctl.wr_reg == bcm_pkg::CLK_DAYH) begin
                    day_reg[8] <= ctl.wr_data[0];
                    halt_reg   <= ctl.wr_data[6];
                    carry_reg  <= ctl.wr_data[7];
                    lat_reg[4] <= {ctl.wr_data[7], ctl.wr_data[6], 5'b00000, ctl.wr_data[0]};
                end else if (halt_reg) begin
                    case (ctl.wr_reg)
                        bcm_pkg::CLK_SEC: begin
                            sec_reg    <= ctl.wr_data[5:0];
                            lat_reg[0] <= {2'b00, ctl.wr_data[5:0]};
                        end
                        bcm_pkg::CLK_MIN: begin
                            min_reg    <= ctl.wr_data[5:0];
                            lat_reg[1] <= {2'b00, ctl.wr_data[5:0]};
                        end
                        bcm_pkg::CLK_HOUR: begin
                            hour_reg   <= ctl.wr_data[4:0];
                            lat_reg[2] <= {3'b000, ctl.wr_data[4:0]};
                        end
                        bcm_pkg::CLK_DAYL: begin
                            day_reg[7:0] <= ctl.wr_data;
                            lat_reg[3]   <= ctl.wr_data;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

endmodule

@@ hw/rtl/banked_cartridge_mapper_rtc.sv @@
// Top level of the banked cartridge mapper with real-time clock.
// Depends on bcm_pkg, bcm_rtc and banked_cartridge_mapper_rtc_assert.svh.
//
// Usage:
//   The slave channel takes one request per handshake: a bus read, a bus write or a
//   clock tick, kind in s_tuser. Writes and ticks produce nothing on the master
//   channel; every read produces exactly one result, in request order.
//   A read below 0x8000 returns from_rom=1 with the physical ROM byte address; a
//   read of 0xA000-0xBFFF returns cartridge RAM, a latched clock byte, or 0xFF.
//   A read result is registered in the RAM read stage when the request is accepted,
//   then in the output register, and is then valid on the master channel. Throughput:
//   one request per cycle unless m_tready stalls with both stages full, set by the
//   single RAM port that serves one read or one write per cycle.
//   The write of ticks_per_second through cfg_we/cfg_wdata is registered in tps_reg.
//   Reset clears the mapper and clock state; cartridge RAM is not cleared and
//   reads undefined until written, so no clearing pass is run.
//   When m_tready is low, the output register holds its result and one more
//   request is still taken into the RAM read stage; then s_tready drops until
//   the output register drains.
module banked_cartridge_mapper_rtc #(
    parameter int RAM_BANK_BYTES = bcm_pkg::RAM_BANK_BYTES_DEF,
    parameter int RAM_BANKS      = bcm_pkg::RAM_BANKS_DEF,
    parameter int ROM_BANK_BITS  = bcm_pkg::ROM_BANK_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: ticks_per_second
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] read_data, [28:8] rom_address, [31:29] zero
    output logic [0:0]  m_tuser    // [0] from_rom
);

    `include "banked_cartridge_mapper_rtc_assert.svh"

    localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam logic [13:0] BANK_BYTES_W  = 14'(RAM_BANK_BYTES);
    localparam logic [6:0]  ROM_BANK_MASK = 7'((1 << ROM_BANK_BITS) - 1);

    // Mapper registers
    logic [23:0] tps_reg;
    logic [6:0]  rom_bank_reg;
    logic [3:0]  ram_select_reg;
    logic        enable_reg;
    logic        latch_armed_reg;

    // Read stage and output register
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_use_ram_reg;
    logic [7:0]  s1_data_reg;
    logic        s1_from_rom_reg;
    logic [20:0] s1_rom_reg;
    logic [7:0]  ram_rd_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg;
    logic        out_from_rom_reg;
    logic [20:0] out_rom_reg;

    logic [7:0]  cart_ram [RAM_DEPTH];

    logic [1:0]  req;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        acc;
    logic        move1;
    logic        in_ram_win;
    logic        sel_is_ram;
    logic        sel_is_clk;
    logic [13:0] offset;
    logic [16:0] ram_index_full;
    logic [RAM_AW-1:0] ram_index;
    logic [6:0]  bank_masked;
    logic [6:0]  bank_eff;
    logic        ram_wr;
    logic        ram_rd;
    logic [7:0]  rd_data;
    logic        rd_from_rom;
    logic [20:0] rd_rom;
    logic [7:0]  rtc_byte;
    bcm_pkg::rtc_ctl_t rtc_ctl;

    assign req   = s_tuser;
    assign addr  = s_tdata[15:0];
    assign wdata = s_tdata[23:16];

    // Handshake: the read stage moves on whenever the output register is free
    assign move1    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || move1;
    assign acc      = s_tvalid && s_tready;

    // Decode the RAM window and the select register
    always_comb begin
        in_ram_win = (addr[15:13] == 3'b101) && enable_reg;
        sel_is_ram = (5'(ram_select_reg) < 5'(RAM_BANKS));
        sel_is_clk = (ram_select_reg >= bcm_pkg::SEL_CLK_FIRST) &&
                     (ram_select_reg <= bcm_pkg::SEL_CLK_LAST);
    end

    // Mirror the window offset into one bank, then index the bank
    always_comb begin
        offset = {1'b0, addr[12:0]};
        for (int i = 0; i < 3; i++) begin
            if (offset >= BANK_BYTES_W) begin
                offset = offset - BANK_BYTES_W;
            end
        end
        ram_index_full = 17'(ram_select_reg) * 17'(RAM_BANK_BYTES) + 17'(offset);
        ram_index      = ram_index_full[RAM_AW-1:0];
    end

    // Map the ROM bank; bank 0 reads as bank 1
    always_comb begin
        bank_masked = rom_bank_reg & ROM_BANK_MASK;
        bank_eff    = (bank_masked == 7'd0) ? 7'd1 : bank_masked;
    end

    assign ram_wr = acc && (req == bcm_pkg::REQ_WRITE) && in_ram_win && sel_is_ram;
    assign ram_rd = acc && (req == bcm_pkg::REQ_READ) && in_ram_win && sel_is_ram;

    // Form the read result except for RAM data
    always_comb begin
        rd_data     = bcm_pkg::OPEN_BUS;
        rd_from_rom = 1'b0;
        rd_rom      = '0;
        if (addr[15:14] == 2'b00) begin
            rd_data     = 8'h00;
            rd_from_rom = 1'b1;
            rd_rom      = {7'd0, addr[13:0]};
        end else if (addr[15:14] == 2'b01) begin
            rd_data     = 8'h00;
            rd_from_rom = 1'b1;
            rd_rom      = {bank_eff, addr[13:0]};
        end else if (in_ram_win && !sel_is_ram && sel_is_clk) begin
            rd_data = rtc_byte;
        end
    end

    // Drive the clock
    always_comb begin
        rtc_ctl.tick    = acc && (req == bcm_pkg::REQ_TICK);
        rtc_ctl.latch   = acc && (req == bcm_pkg::REQ_WRITE) && (addr[15:13] == 3'b011) &&
                          latch_armed_reg && (wdata == bcm_pkg::LATCH_FIRE);
        rtc_ctl.wr_en   = acc && (req == bcm_pkg::REQ_WRITE) && in_ram_win &&
                          !sel_is_ram && sel_is_clk;
        rtc_ctl.wr_reg  = 3'(ram_select_reg - bcm_pkg::SEL_CLK_FIRST);
        rtc_ctl.wr_data = wdata;
    end

    bcm_rtc u_rtc (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (rtc_ctl),
        .ticks_per_second (tps_reg),
        .rd_sel           (3'(ram_select_reg - bcm_pkg::SEL_CLK_FIRST)),
        .rd_byte          (rtc_byte)
    );

    // Update mapper registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg         <= bcm_pkg::TPS_RESET;
            rom_bank_reg    <= '0;
            ram_select_reg  <= '0;
            enable_reg      <= 1'b0;
            latch_armed_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                tps_reg <= cfg_wdata;
            end
            if (acc && (req == bcm_pkg::REQ_WRITE)) begin
                case (addr[15:13])
                    3'b000:  enable_reg     <= (wdata[3:0] == bcm_pkg::ENABLE_KEY);
                    3'b001:  rom_bank_reg   <= wdata[6:0];
                    3'b010:  ram_select_reg <= wdata[3:0];
                    default: begin
                    end
                endcase
                if (addr[15:13] == 3'b011) begin
                    latch_armed_reg <= (wdata == bcm_pkg::LATCH_ARM);
                end
            end
        end
    end

    // Cartridge RAM: one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (ram_wr) begin
            cart_ram[ram_index] <= wdata;
        end
        if (ram_rd) begin
            ram_rd_reg <= cart_ram[ram_index];
        end
    end

    // Advance the read stage and output register
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (acc) begin
            s1_valid_next = (req == bcm_pkg::REQ_READ);
        end else if (move1) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = move1 ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payloads in their stage until they move
    always_ff @(posedge aclk) begin
        if (acc && (req == bcm_pkg::REQ_READ)) begin
            s1_use_ram_reg  <= in_ram_win && sel_is_ram && (addr[15:14] == 2'b10);
            s1_data_reg     <= rd_data;
            s1_from_rom_reg <= rd_from_rom;
            s1_rom_reg      <= rd_rom;
        end
        if (move1) begin
            out_data_reg     <= s1_use_ram_reg ? ram_rd_reg : s1_data_reg;
            out_from_rom_reg <= s1_from_rom_reg;
            out_rom_reg      <= s1_rom_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_rom_reg, out_data_reg};
    assign m_tuser  = out_from_rom_reg;

    // Checks
    `BCM_ASSERT_IMPL(a_rom_data_zero, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'h00,
        "ROM result carries nonzero read data")
    `BCM_ASSERT_IMPL(a_rom_addr_zero, m_tvalid && !m_tuser[0], m_tdata[28:8] == 21'd0,
        "non-ROM result carries a ROM address")
    `BCM_ASSERT_NEXT(a_read_enters, acc && (req == bcm_pkg::REQ_READ), s1_valid_reg,
        "accepted read did not enter the read stage")
    `BCM_ASSERT_IMPL(a_stall_blocks, s1_valid_reg && out_valid_reg && !m_tready, !s_tready,
        "request taken while both stages are full and stalled")

endmodule

@@ dv/banked_cartridge_mapper_rtc_checker.sv @@
// Checker for the cartridge mapper: watches the request, result and config ports,
// predicts every read result and compares it field by field. Depends on bcm_pkg.
module banked_cartridge_mapper_rtc_checker
    import bcm_pkg::*;
#(
    parameter int RAM_BANK_BYTES = RAM_BANK_BYTES_DEF,
    parameter int RAM_BANKS      = RAM_BANKS_DEF,
    parameter int ROM_BANK_BITS  = ROM_BANK_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [7:0] read_data, [28:8] rom_address, [31:29] zero
    input  logic [0:0]  m_tuser,   // [0] from_rom
    output int          mismatches,
    output int          reads_open
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [7:0]  data;
        logic        from_rom;
        logic [20:0] rom_addr;
    } read_result_t;

    read_result_t pending_reads[$];

    // Mapper and clock state of the prediction
    logic [23:0] tick_limit;
    logic [6:0]  rom_bank;
    logic [3:0]  ram_sel;
    logic        ram_on;
    logic        latch_armed;
    logic [23:0] sub_count;
    logic [5:0]  secs;
    logic [5:0]  mins;
    logic [4:0]  hours;
    logic [8:0]  days;
    logic        halted;
    logic        day_carry;
    logic [7:0]  latched [5];
    logic [7:0]  cart_ram [RAM_BANKS * RAM_BANK_BYTES];

    function automatic logic [7:0] day_high();
        return {day_carry, halted, 5'b0, days[8]};
    endfunction

    function automatic int ram_index(input logic [15:0] addr);
        return int'(ram_sel) * RAM_BANK_BYTES + (int'(addr) - 'hA000) % RAM_BANK_BYTES;
    endfunction

    task automatic clear_state();
        tick_limit  = TPS_RESET;
        rom_bank    = '0;
        ram_sel     = '0;
        ram_on      = 1'b0;
        latch_armed = 1'b0;
        sub_count   = '0;
        secs        = '0;
        mins        = '0;
        hours       = '0;
        days        = '0;
        halted      = 1'b0;
        day_carry   = 1'b0;
        foreach (latched[i]) latched[i] = '0;
    endtask

    task automatic latch_clock();
        latched[CLK_SEC]  = {2'b0, secs};
        latched[CLK_MIN]  = {2'b0, mins};
        latched[CLK_HOUR] = {3'b0, hours};
        latched[CLK_DAYL] = days[7:0];
        latched[CLK_DAYH] = day_high();
    endtask

    // Ripple one second through the clock; in-range fields wrap with carry
    task automatic advance_second();
        if (secs != 6'd59) begin
            secs = secs + 6'd1;
        end else begin
            secs = '0;
            if (mins != 6'd59) begin
                mins = mins + 6'd1;
            end else begin
                mins = '0;
                if (hours != 5'd23) begin
                    hours = hours + 5'd1;
                end else begin
                    hours = '0;
                    if (days == 9'd511) day_carry = 1'b1;
                    days = days + 9'd1;
                end
            end
        end
    endtask

    // Day-high always writes; the other clock registers only while halted
    task automatic write_clock(input logic [2:0] idx, input logic [7:0] v);
        if (idx == CLK_DAYH) begin
            days[8]           = v[0];
            halted            = v[6];
            day_carry         = v[7];
            latched[CLK_DAYH] = day_high();
        end else if (halted) begin
            case (idx)
                CLK_SEC: begin
                    secs             = v[5:0];
                    latched[CLK_SEC] = {2'b0, secs};
                end
                CLK_MIN: begin
                    mins             = v[5:0];
                    latched[CLK_MIN] = {2'b0, mins};
                end
                CLK_HOUR: begin
                    hours             = v[4:0];
                    latched[CLK_HOUR] = {3'b0, hours};
                end
                default: begin
                    days[7:0]         = v;
                    latched[CLK_DAYL] = v;
                end
            endcase
        end
    endtask

    task automatic apply_request(input logic [1:0] kind, input logic [15:0] addr,
                                 input logic [7:0] data);
        read_result_t res;
        int unsigned  bank;
        logic [24:0]  next_count;
        logic [23:0]  limit;
        logic         in_window;
        in_window = (addr >= 16'hA000) && (addr < 16'hC000);
        case (kind)
            REQ_TICK: begin
                if (!halted) begin
                    limit      = (tick_limit == '0) ? 24'd1 : tick_limit;
                    next_count = {1'b0, sub_count} + 25'd1;
                    if (next_count >= {1'b0, limit}) begin
                        sub_count = '0;
                        advance_second();
                    end else begin
                        sub_count = next_count[23:0];
                    end
                end
            end
            REQ_WRITE: begin
                if (addr < 16'h2000) begin
                    ram_on = (data[3:0] == ENABLE_KEY);
                end else if (addr < 16'h4000) begin
                    rom_bank = data[6:0];
                end else if (addr < 16'h6000) begin
                    ram_sel = data[3:0];
                end else if (addr < 16'h8000) begin
                    if (latch_armed && data == LATCH_FIRE) latch_clock();
                    latch_armed = (data == LATCH_ARM);
                end else if (in_window && ram_on) begin
                    if (ram_sel < RAM_BANKS)
                        cart_ram[ram_index(addr)] = data;
                    else if (ram_sel >= SEL_CLK_FIRST && ram_sel <= SEL_CLK_LAST)
                        write_clock(3'(ram_sel - SEL_CLK_FIRST), data);
                end
            end
            REQ_READ: begin
                res = '{data: OPEN_BUS, from_rom: 1'b0, rom_addr: '0};
                if (addr < 16'h4000) begin
                    res.data     = '0;
                    res.from_rom = 1'b1;
                    res.rom_addr = 21'(addr);
                end else if (addr < 16'h8000) begin
                    bank = int'(rom_bank) & ((1 << ROM_BANK_BITS) - 1);
                    if (bank == 0) bank = 1;
                    res.data     = '0;
                    res.from_rom = 1'b1;
                    res.rom_addr = 21'(bank * 32'h4000 + (32'(addr) - 32'h4000));
                end else if (in_window && ram_on) begin
                    if (ram_sel < RAM_BANKS)
                        res.data = cart_ram[ram_index(addr)];
                    else if (ram_sel >= SEL_CLK_FIRST && ram_sel <= SEL_CLK_LAST)
                        res.data = latched[3'(ram_sel - SEL_CLK_FIRST)];
                end
                pending_reads.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    task automatic check_result();
        read_result_t want;
        if (pending_reads.size() == 0) begin
            flag_mismatch("unrequested result", '0, m_tdata);
        end else begin
            want = pending_reads.pop_front();
            if (m_tdata[7:0] !== want.data)
                flag_mismatch("read_data", 32'(want.data), 32'(m_tdata[7:0]));
            if (m_tdata[28:8] !== want.rom_addr)
                flag_mismatch("rom_address", 32'(want.rom_addr), 32'(m_tdata[28:8]));
            if (m_tuser[0] !== want.from_rom)
                flag_mismatch("from_rom", 32'(want.from_rom), 32'(m_tuser[0]));
            if (m_tdata[31:29] !== 3'b0)
                flag_mismatch("tdata pad", '0, 32'(m_tdata[31:29]));
        end
    endtask

    // Compare results first; a request taken at this edge cannot answer at it
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            pending_reads.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (cfg_we) tick_limit = cfg_wdata;
            if (s_tvalid && s_tready) apply_request(s_tuser, s_tdata[15:0], s_tdata[23:16]);
        end
        reads_open <= pending_reads.size();
    end

endmodule

@@ dv/tb_banked_cartridge_mapper_rtc.sv @@
// Top of the cartridge mapper testbench: clock, reset, request and config stimulus,
// result backpressure and the verdict. Depends on bcm_pkg, the RTL and the checker.
module tb_banked_cartridge_mapper_rtc;
    timeunit 1ns;
    timeprecision 1ps;
    import bcm_pkg::*;

    localparam int          RAM_BANK_BYTES = RAM_BANK_BYTES_DEF;
    localparam int          RAM_BANKS      = RAM_BANKS_DEF;
    localparam int          RAM_BYTES      = RAM_BANK_BYTES * RAM_BANKS;
    localparam int          RESET_CYCLES   = 12;
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          READ_LATENCY   = 2;
    localparam int          POOL_SIZE      = 16;
    localparam logic [1:0]  REQ_BAD        = 2'd3;
    localparam logic [15:0] ENABLE_BASE    = 16'h0000;
    localparam logic [15:0] BANK_BASE      = 16'h2000;
    localparam logic [15:0] SELECT_BASE    = 16'h4000;
    localparam logic [15:0] LATCH_BASE     = 16'h6000;
    localparam logic [15:0] WINDOW_BASE    = 16'hA000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = REQ_READ;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    int mismatches;
    int reads_open;
    int cycle_count = 0;
    int requests_sent = 0;
    int reads_sent = 0;
    bit calm = 1'b0;

    // Stimulus-side view of the mapper, used to keep reads off unwritten RAM
    logic        view_on  = 1'b0;
    logic [3:0]  view_sel = '0;
    bit          ram_written [RAM_BYTES];
    logic [15:0] ram_pool [POOL_SIZE];

    banked_cartridge_mapper_rtc DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    banked_cartridge_mapper_rtc_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .reads_open (reads_open)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL banked_cartridge_mapper_rtc");
            $finish;
        end
    end

    // Stall the result channel in random bursts until the calm stretch
    initial begin
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic [15:0] in_region(input logic [15:0] base);
        return base + 16'($urandom_range(0, 16'h1FFF));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Present one request and hold it until taken, then maybe idle
    task automatic send_req(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] data);
        logic [1:0] k;
        int         idx;
        k = kind;
        if (addr >= 16'hA000 && addr < 16'hC000 && view_on && view_sel < RAM_BANKS) begin
            idx = int'(view_sel) * RAM_BANK_BYTES + (int'(addr) - 'hA000) % RAM_BANK_BYTES;
            // turn a read of an unwritten byte into a write of it
            if (k == REQ_READ && !ram_written[idx]) k = REQ_WRITE;
            if (k == REQ_WRITE) ram_written[idx] = 1'b1;
        end
        if (k == REQ_WRITE && addr < 16'h2000) view_on = (data[3:0] == ENABLE_KEY);
        if (k == REQ_WRITE && addr >= 16'h4000 && addr < 16'h6000) view_sel = data[3:0];
        s_tvalid <= 1'b1;
        s_tdata  <= {data, addr};
        s_tuser  <= k;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (k != REQ_BAD) requests_sent++;
        if (k == REQ_READ) reads_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic wr(input logic [15:0] addr, input logic [7:0] data);
        send_req(REQ_WRITE, addr, data);
    endtask

    task automatic rd(input logic [15:0] addr);
        send_req(REQ_READ, addr, rand_byte());
    endtask

    task automatic tick();
        send_req(REQ_TICK, 16'($urandom_range(0, 16'hFFFF)), rand_byte());
    endtask

    task automatic enable_ram();
        wr(in_region(ENABLE_BASE), {4'($urandom_range(0, 15)), ENABLE_KEY});
    endtask

    task automatic select(input logic [3:0] sel);
        wr(in_region(SELECT_BASE), {4'($urandom_range(0, 15)), sel});
    endtask

    task automatic latch_and_read_clock();
        // mostly a proper arm-then-fire, sometimes a broken one
        wr(in_region(LATCH_BASE), ($urandom_range(0, 3) == 0) ? rand_byte() : LATCH_ARM);
        wr(in_region(LATCH_BASE), ($urandom_range(0, 3) == 0) ? rand_byte() : LATCH_FIRE);
        for (int r = SEL_CLK_FIRST; r <= SEL_CLK_LAST; r++) begin
            select(4'(r));
            rd(in_region(WINDOW_BASE));
        end
    endtask

    // Wait for every read to come back, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reads_open != 0) @(posedge aclk);
        repeat (READ_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic set_tick_rate(input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_episode();
        int pick;
        int n;
        pick = $urandom_range(0, 7);
        case (pick)
            0: begin
                // bank switch and ROM reads
                wr(in_region(BANK_BASE), rand_byte());
                n = $urandom_range(1, 6);
                repeat (n) rd(16'($urandom_range(0, 16'h7FFF)));
            end
            1, 2: begin
                // RAM session on one bank, reads and writes over a small address pool
                enable_ram();
                select(4'($urandom_range(0, RAM_BANKS - 1)));
                n = $urandom_range(2, 10);
                repeat (n) begin
                    if ($urandom_range(0, 1) == 0)
                        wr(ram_pool[$urandom_range(0, POOL_SIZE - 1)], rand_byte());
                    else
                        rd(ram_pool[$urandom_range(0, POOL_SIZE - 1)]);
                end
                if ($urandom_range(0, 3) == 0) begin
                    wr(in_region(ENABLE_BASE), rand_byte());
                    rd(ram_pool[$urandom_range(0, POOL_SIZE - 1)]);
                end
            end
            3: begin
                enable_ram();
                latch_and_read_clock();
            end
            4: begin
                // halt, load a time near rollover, run it, latch and read back
                enable_ram();
                select(SEL_CLK_LAST);
                wr(in_region(WINDOW_BASE), 8'h40 | (rand_byte() & 8'hBF));
                select(SEL_CLK_FIRST + CLK_SEC);
                wr(in_region(WINDOW_BASE), ($urandom_range(0, 1) == 0) ? 8'd59 : rand_byte());
                select(SEL_CLK_FIRST + CLK_MIN);
                wr(in_region(WINDOW_BASE), ($urandom_range(0, 1) == 0) ? 8'd59 : rand_byte());
                select(SEL_CLK_FIRST + CLK_HOUR);
                wr(in_region(WINDOW_BASE), ($urandom_range(0, 1) == 0) ? 8'd23 : rand_byte());
                select(SEL_CLK_FIRST + CLK_DAYL);
                wr(in_region(WINDOW_BASE), ($urandom_range(0, 1) == 0) ? 8'hFF : rand_byte());
                repeat ($urandom_range(0, 3)) tick();
                select(SEL_CLK_LAST);
                if ($urandom_range(0, 5) == 0)
                    wr(in_region(WINDOW_BASE), rand_byte());
                else
                    wr(in_region(WINDOW_BASE), rand_byte() & 8'hBF);
                n = $urandom_range(1, 40);
                repeat (n) tick();
                latch_and_read_clock();
            end
            5: begin
                n = $urandom_range(1, 30);
                repeat (n) tick();
                enable_ram();
                wr(in_region(LATCH_BASE), LATCH_ARM);
                wr(in_region(LATCH_BASE), LATCH_FIRE);
                select(SEL_CLK_FIRST + CLK_SEC);
                rd(in_region(WINDOW_BASE));
            end
            6: begin
                // selects that map nothing
                enable_ram();
                if ($urandom_range(0, 1) == 0)
                    select(4'($urandom_range(RAM_BANKS, SEL_CLK_FIRST - 1)));
                else
                    select(4'($urandom_range(SEL_CLK_LAST + 1, 15)));
                wr(in_region(WINDOW_BASE), rand_byte());
                rd(in_region(WINDOW_BASE));
            end
            default: begin
                // noise over every request kind and address
                n = $urandom_range(1, 8);
                repeat (n) send_req(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
                                    rand_byte());
            end
        endcase
    endtask

    task automatic run_random(input int count);
        int first;
        first = requests_sent;
        while (requests_sent - first < count) run_episode();
    endtask

    initial begin
        ram_pool[0] = WINDOW_BASE;
        ram_pool[1] = WINDOW_BASE + 16'(RAM_BANK_BYTES - 1);
        for (int i = 2; i < POOL_SIZE; i++)
            ram_pool[i] = WINDOW_BASE + 16'($urandom_range(0, RAM_BANK_BYTES - 1));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: ROM boundaries, bank masking, open bus, RAM boundaries, clock registers
        rd(16'h0000);
        rd(16'h4000);
        rd(16'h7FFF);
        wr(16'h2000, 8'hFF);
        rd(16'h7FFF);
        wr(16'h3FFF, 8'h80);
        rd(16'h4000);
        rd(16'h8000);
        rd(16'hFFFF);
        rd(16'hA000);
        wr(16'h0000, {4'hF, ENABLE_KEY});
        wr(16'h4000, 8'h00);
        wr(16'hA000, 8'h00);
        wr(16'hBFFF, 8'hFF);
        rd(16'hA000);
        rd(16'hBFFF);
        wr(16'h5FFF, 8'h0F);
        rd(16'hA000);
        wr(16'h4000, {4'h0, SEL_CLK_LAST});
        wr(16'hA000, 8'hC1);
        rd(16'hA000);
        wr(16'h4000, {4'h0, SEL_CLK_FIRST});
        wr(16'hA000, 8'hFF);
        send_req(REQ_BAD, 16'hFFFF, 8'hFF);
        tick();
        wr(16'h1FFF, 8'h0B);
        rd(16'hBFFF);

        run_random(170);
        settle();
        set_tick_rate(24'd1);
        run_random(170);
        settle();
        set_tick_rate(24'($urandom_range(2, 7)));
        run_random(170);
        settle();
        set_tick_rate(24'hFFFFFF);
        run_random(150);
        settle();
        set_tick_rate(24'd1);
        calm = 1'b1;
        run_random(170);
        settle();

        $display("Sent %0d requests (%0d reads) over five tick rates, incl. clock rollover.",
                 requests_sent, reads_sent);
        if (mismatches == 0) begin
            $display("PASS banked_cartridge_mapper_rtc");
        end else begin
            $display("FAIL banked_cartridge_mapper_rtc");
        end
        $finish;
    end

endmodule
